// File: src/efdc_pkg.sv
package efdc_pkg;

  // largest payload a frame may carry
  localparam int unsigned MaxPayload = 11;
  localparam int unsigned CntW       = $clog2(MaxPayload + 1);
  localparam int unsigned IdxW       = $clog2(MaxPayload);

  localparam logic [7:0] SymStart = 8'hEA;
  localparam logic [7:0] SymEnd   = 8'hED;
  localparam logic [7:0] SymEsc   = 8'hEB;

  localparam logic [7:0] CmdDirection = 8'h01;
  localparam logic [7:0] ArgOne       = 8'h01;
  localparam logic [7:0] ArgZero      = 8'h00;

  // direction flag bits
  localparam int unsigned FlagUp   = 0;
  localparam int unsigned FlagDown = 1;
  localparam int unsigned FlagStop = 2;

  localparam logic [2:0] FlagsUpStop   = 3'b101;
  localparam logic [2:0] FlagsDownStop = 3'b110;
  localparam logic [2:0] FlagsNone     = 3'b000;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_START,
    KIND_END,
    KIND_ESC
  } sym_kind_e;

  typedef struct packed {
    sym_kind_e  kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic       motor_stop_request;
    logic       stop_command;
    logic       down_command;
    logic       up_command;
    logic [7:0] command_code;
    logic       checksum_bad;
    logic [3:0] frame_length;
  } result_t;

  localparam int unsigned ResW  = $bits(result_t);
  localparam int unsigned OutDW = ((ResW + 7) / 8) * 8;

endpackage

// File: src/efdc_front.sv
module efdc_front (
  input  logic           in_valid_i,
  input  logic [7:0]     in_data_i,
  output logic           in_ready_o,
  input  logic           q_full_i,
  output logic           push_o,
  output efdc_pkg::item_t item_o
);
  import efdc_pkg::*;

  sym_kind_e kind;

  always_comb begin
    unique case (in_data_i)
      SymStart: kind = KIND_START;
      SymEnd:   kind = KIND_END;
      SymEsc:   kind = KIND_ESC;
      default:  kind = KIND_DATA;
    endcase
  end

  assign in_ready_o  = !q_full_i;
  assign push_o      = in_valid_i && !q_full_i;
  assign item_o.kind = kind;
  assign item_o.data = in_data_i;

endmodule

// File: src/efdc_queue.sv
module efdc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  efdc_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output efdc_pkg::item_t item_o
);
  import efdc_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// File: src/efdc_back.sv
module efdc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              op_valid_i,
  input  efdc_pkg::item_t   op_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output efdc_pkg::result_t out_o
);
  import efdc_pkg::*;

  logic            in_frame_q, in_frame_d;
  logic            esc_q, esc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      last_q;
  logic [7:0]      store_q [MaxPayload];
  logic [2:0]      flags_q, flags_d;
  logic            out_valid_q, out_valid_d;
  result_t         out_q, res;

  logic       produce, wr_en;
  logic [7:0] last_byte;
  logic       bad, stop_req;

  // only a closing byte needs a free output slot
  assign produce = in_frame_q && !esc_q && (op_i.kind == KIND_END);
  assign pop_o   = op_valid_i && (!produce || !out_valid_q || out_ready_i);

  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    cnt_d      = cnt_q;
    sum_d      = sum_q;
    flags_d    = flags_q;
    wr_en      = 1'b0;
    stop_req   = 1'b0;

    last_byte = (cnt_q == '0) ? 8'h00 : last_q;
    bad       = (sum_q != last_byte);

    if (pop_o) begin
      if (!in_frame_q) begin
        if (op_i.kind == KIND_START) begin
          in_frame_d = 1'b1;
          esc_d      = 1'b0;
          cnt_d      = '0;
          sum_d      = 8'h00;
        end
      end else if (esc_q || op_i.kind == KIND_DATA) begin
        if (esc_q && op_i.kind == KIND_DATA) begin
          // escaped ordinary byte aborts the frame
          in_frame_d = 1'b0;
          esc_d      = 1'b0;
          cnt_d      = '0;
          sum_d      = 8'h00;
        end else if (cnt_q >= CntW'(MaxPayload)) begin
          in_frame_d = 1'b0;
          esc_d      = 1'b0;
          cnt_d      = '0;
          sum_d      = 8'h00;
        end else begin
          wr_en = 1'b1;
          if (cnt_q != '0) begin
            sum_d = sum_q + last_q;
          end
          cnt_d = cnt_q + CntW'(1);
          esc_d = 1'b0;
        end
      end else if (op_i.kind == KIND_ESC) begin
        esc_d = 1'b1;
      end else if (op_i.kind == KIND_END) begin
        in_frame_d = 1'b0;
        esc_d      = 1'b0;
        if (!bad && store_q[1] == CmdDirection) begin
          if (store_q[2] == ArgOne) begin
            stop_req = 1'b1;
            if (store_q[3] == ArgOne) begin
              flags_d = FlagsUpStop;
            end else if (store_q[3] == ArgZero) begin
              flags_d = FlagsDownStop;
            end
          end else if (store_q[2] == ArgZero) begin
            flags_d = FlagsNone;
          end
        end
      end else begin
        // start inside a frame restarts it
        in_frame_d = 1'b1;
        esc_d      = 1'b0;
        cnt_d      = '0;
        sum_d      = 8'h00;
      end
    end

    res.frame_length       = 4'(cnt_q);
    res.checksum_bad       = bad;
    res.command_code       = store_q[1];
    res.up_command         = flags_d[FlagUp];
    res.down_command       = flags_d[FlagDown];
    res.stop_command       = flags_d[FlagStop];
    res.motor_stop_request = stop_req;

    out_valid_d = out_valid_q && !out_ready_i;
    if (pop_o && produce) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxPayload; i++) begin
        store_q[i] <= 8'h00;
      end
    end else if (wr_en) begin
      store_q[cnt_q[IdxW-1:0]] <= op_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      last_q <= op_i.data;
    end
    if (pop_o && produce) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      esc_q       <= 1'b0;
      cnt_q       <= '0;
      sum_q       <= 8'h00;
      flags_q     <= FlagsNone;
      out_valid_q <= 1'b0;
    end else begin
      in_frame_q  <= in_frame_d;
      esc_q       <= esc_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: src/escaped_frame_decoder_checksum_top.sv
// byte-stuffed frame decoder: takes one received byte per transfer, one byte per
// clock sustained unless a closing byte waits on a stalled result. frames open
// with 0xea and close with 0xed; 0xeb makes the following special byte literal,
// and an escaped ordinary byte or a payload longer than 11 bytes drops the frame
// silently. each closed frame gives one result transfer carrying its length, a
// checksum flag (mod-256 sum of all payload bytes but the last, compared with the
// last), the command byte at payload position two and the held up/down/stop
// command flags, plus a one-shot motor stop request. bytes pass a two-entry queue
// into the frame engine: a closing byte is held in the queue, then its result in
// the result register, before the result is offered. only a closing byte waits
// on a full result register; other bytes keep flowing while a result is stalled
module escaped_frame_decoder_checksum_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // rx_byte [7:0]
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,
  // frame_length [3:0], checksum_bad [4], command_code [12:5], up_command [13],
  // down_command [14], stop_command [15], motor_stop_request [16], zeros above
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [efdc_pkg::OutDW-1:0]    m_axis_tdata
);
  import efdc_pkg::*;

  item_t   push_item, head_item;
  logic    push, q_full, q_valid, pop;
  result_t res;

  // front end: byte classification and input handshake
  efdc_front u_front (
    .in_valid_i (s_axis_tvalid),
    .in_data_i  (s_axis_tdata),
    .in_ready_o (s_axis_tready),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (push_item)
  );

  // decoupling queue between classifier and frame engine
  efdc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  // back end: frame state, payload store, checksum and command decode
  efdc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (head_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = OutDW'(res);

endmodule

// File: src/efdc_checker.sv
module efdc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no result straight out of reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid out of reset");

  // stop request only from a good direction command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[16] |->
      !m_axis_tdata[4] && m_axis_tdata[12:5] == 8'h01)
    else $error("stop request without good command");

  // up and down never held together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[13] && m_axis_tdata[14]))
    else $error("up and down both held");

  // length within the payload store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd11)
    else $error("frame length beyond store");

endmodule

bind escaped_frame_decoder_checksum_top efdc_checker u_efdc_checker (.*);

// File: tb/sv/efdc_frame_checker.sv
module efdc_frame_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [7:0]                    s_tdata_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [efdc_pkg::OutDW-1:0]    m_tdata_i,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   frames_pending_o,
  output int unsigned                   frames_done_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import efdc_pkg::*;

  // shadow of the deframer state
  logic              in_frame_q;
  logic              esc_pending_q;
  int unsigned       payload_cnt_q;
  logic [7:0]        payload_q [MaxPayload];
  logic [7:0]        partial_sum_q;
  logic [2:0]        dir_flags_q;

  result_t           closed_frames_q [$];

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count_o++;
    $display("[%0t] frame %0d: %s is %0h, expected %0h", $time, frames_done_o, what, got,
             want);
  endtask

  // open (restart) or drop: both empty the count and the sum
  task automatic clear_frame(input logic opening);
    in_frame_q    = opening;
    esc_pending_q = 1'b0;
    payload_cnt_q = 0;
    partial_sum_q = 8'h00;
  endtask

  task automatic keep_payload_byte(input logic [7:0] b);
    if (payload_cnt_q >= MaxPayload) begin
      clear_frame(1'b0);
    end else begin
      if (payload_cnt_q > 0) partial_sum_q = partial_sum_q + payload_q[payload_cnt_q - 1];
      payload_q[payload_cnt_q] = b;
      payload_cnt_q++;
      esc_pending_q = 1'b0;
    end
  endtask

  task automatic close_frame();
    logic [7:0] last_byte;
    logic       stop_pulse;
    result_t    r;
    in_frame_q    = 1'b0;
    esc_pending_q = 1'b0;
    stop_pulse    = 1'b0;
    last_byte     = (payload_cnt_q == 0) ? 8'h00 : payload_q[payload_cnt_q - 1];
    // bytes two to four may be left over from an earlier frame
    if (partial_sum_q == last_byte && payload_q[1] == CmdDirection) begin
      if (payload_q[2] == ArgOne) begin
        stop_pulse = 1'b1;
        if (payload_q[3] == ArgOne) dir_flags_q = FlagsUpStop;
        else if (payload_q[3] == ArgZero) dir_flags_q = FlagsDownStop;
      end else if (payload_q[2] == ArgZero) begin
        dir_flags_q = FlagsNone;
      end
    end
    r                    = '0;
    r.frame_length       = payload_cnt_q[3:0];
    r.checksum_bad       = (partial_sum_q != last_byte);
    r.command_code       = payload_q[1];
    r.up_command         = dir_flags_q[FlagUp];
    r.down_command       = dir_flags_q[FlagDown];
    r.stop_command       = dir_flags_q[FlagStop];
    r.motor_stop_request = stop_pulse;
    closed_frames_q.push_back(r);
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    if (!in_frame_q) begin
      if (b == SymStart) clear_frame(1'b1);
    end else if (esc_pending_q) begin
      if (b == SymStart || b == SymEsc || b == SymEnd) keep_payload_byte(b);
      else clear_frame(1'b0);
    end else if (b == SymEsc) begin
      esc_pending_q = 1'b1;
    end else if (b == SymEnd) begin
      close_frame();
    end else if (b == SymStart) begin
      clear_frame(1'b1);
    end else begin
      keep_payload_byte(b);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      in_frame_q       = 1'b0;
      esc_pending_q    = 1'b0;
      payload_cnt_q    = 0;
      partial_sum_q    = 8'h00;
      dir_flags_q      = FlagsNone;
      for (int i = 0; i < MaxPayload; i++) payload_q[i] = 8'h00;
      closed_frames_q.delete();
      mismatch_count_o = 0;
      frames_pending_o = 0;
      frames_done_o    = 0;
    end else begin
      // a result always stems from an earlier byte, so compare before predicting
      if (m_tvalid_i && m_tready_i) begin
        got = result_t'(m_tdata_i[ResW-1:0]);
        if (closed_frames_q.size() == 0) begin
          report_mismatch("unexpected result", m_tdata_i, 0);
        end else begin
          want = closed_frames_q.pop_front();
          if (got.frame_length != want.frame_length)
            report_mismatch("frame_length", got.frame_length, want.frame_length);
          if (got.checksum_bad != want.checksum_bad)
            report_mismatch("checksum_bad", got.checksum_bad, want.checksum_bad);
          if (got.command_code != want.command_code)
            report_mismatch("command_code", got.command_code, want.command_code);
          if (got.up_command != want.up_command)
            report_mismatch("up_command", got.up_command, want.up_command);
          if (got.down_command != want.down_command)
            report_mismatch("down_command", got.down_command, want.down_command);
          if (got.stop_command != want.stop_command)
            report_mismatch("stop_command", got.stop_command, want.stop_command);
          if (got.motor_stop_request != want.motor_stop_request)
            report_mismatch("motor_stop_request", got.motor_stop_request,
                            want.motor_stop_request);
        end
        if (m_tdata_i[OutDW-1:ResW] != '0)
          report_mismatch("padding", m_tdata_i[OutDW-1:ResW], 0);
        frames_done_o++;
      end
      if (s_tvalid_i && s_tready_i) deframe_byte(s_tdata_i);
      frames_pending_o = closed_frames_q.size();
    end
  end

endmodule

// File: tb/sv/escaped_frame_decoder_checksum_top_tb.sv
module escaped_frame_decoder_checksum_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import efdc_pkg::*;

  // generous upper bound for the whole run
  localparam int unsigned CycleLimit   = 100000;
  localparam int unsigned BytesPerPhase = 100;
  localparam int unsigned DrainCycles  = 10;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = 8'h00;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OutDW-1:0]  m_axis_tdata;

  int unsigned       mismatches;
  int unsigned       frames_pending;
  int unsigned       frames_done;

  // idling odds in percent, changed per phase
  int unsigned       sender_idle_pct    = 0;
  int unsigned       receiver_stall_pct = 0;
  int unsigned       bytes_sent         = 0;
  int unsigned       cycle_count        = 0;

  // short directed prologue: ignored noise, empty frame, a good direction command
  // with stop pulse, escaped special bytes with a bad sum, and an escaped
  // ordinary byte that drops the frame
  logic [7:0] directed_bytes [$] = '{
    8'h00, 8'hFF,
    SymStart, SymEnd,
    SymStart, 8'h00, CmdDirection, ArgOne, ArgOne, 8'h03, SymEnd,
    SymStart, SymEsc, SymStart, SymEsc, SymEnd, SymEsc, SymEsc, SymEnd,
    SymStart, 8'h05, SymEsc, 8'h41
  };

  escaped_frame_decoder_checksum_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  efdc_frame_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .mismatch_count_o (mismatches),
    .frames_pending_o (frames_pending),
    .frames_done_o    (frames_done)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // result side back-pressure, redrawn on every falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // watchdog: a hang or a lost result ends here
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // one byte transfer; gaps are inserted before the byte, never between the
  // lowering and raising of tvalid in the same step
  task automatic send_rx_byte(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  // payload byte with stuffing for the three special symbols
  task automatic send_payload_byte(input logic [7:0] b);
    if (b == SymStart || b == SymEsc || b == SymEnd) send_rx_byte(SymEsc);
    send_rx_byte(b);
  endtask

  // payload content leaning towards special symbols now and then
  function automatic logic [7:0] pick_payload_byte();
    logic [7:0] b;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(2))
          0:       b = SymStart;
          1:       b = SymEsc;
          default: b = SymEnd;
        endcase
      end
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  // command arguments land on the decoded values most of the time
  function automatic logic [7:0] pick_argument();
    logic [7:0] b;
    case ($urandom_range(2))
      0:       b = ArgOne;
      1:       b = ArgZero;
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  // a complete frame, mostly with a matching sum; a few run past the store
  task automatic send_frame();
    logic [7:0]  payload [$];
    logic [7:0]  sum;
    int unsigned len;
    int unsigned odds;
    odds = $urandom_range(99);
    if (odds < 6) len = MaxPayload + 1;
    else if (odds < 16) len = $urandom_range(1);
    else if (odds < 30) len = $urandom_range(4, 2);
    else len = $urandom_range(MaxPayload, 2);
    for (int i = 0; i < len; i++) payload.push_back(pick_payload_byte());
    if (len >= 3 && $urandom_range(1)) begin
      payload[1] = CmdDirection;
      payload[2] = pick_argument();
      if (len >= 4) payload[3] = pick_argument();
    end
    if (len > 0 && $urandom_range(99) < 80) begin
      sum = 8'h00;
      for (int i = 0; i + 1 < len; i++) sum += payload[i];
      payload[len - 1] = sum;
    end
    send_rx_byte(SymStart);
    foreach (payload[i]) send_payload_byte(payload[i]);
    send_rx_byte(SymEnd);
  endtask

  // one random burst: mostly good frames, some line noise, aborted frames
  // and frames restarted by a fresh start byte
  task automatic send_random_burst();
    int unsigned odds;
    odds = $urandom_range(99);
    if (odds < 10) begin
      repeat ($urandom_range(4, 1)) send_rx_byte(8'($urandom_range(255)));
    end else if (odds < 18) begin
      send_rx_byte(SymStart);
      repeat ($urandom_range(3)) send_payload_byte(pick_payload_byte());
      send_rx_byte(SymEsc);
      send_rx_byte(8'($urandom_range(SymStart - 1)));
      if ($urandom_range(1)) send_rx_byte(SymEnd);
    end else if (odds < 26) begin
      send_rx_byte(SymStart);
      repeat ($urandom_range(4, 1)) send_payload_byte(pick_payload_byte());
      send_frame();
    end else begin
      send_frame();
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_bytes[i]) send_rx_byte(directed_bytes[i]);

    // pressure phases: none, sender gaps, receiver stalls, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1:       begin sender_idle_pct = 62; receiver_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  receiver_stall_pct = 62; end
        default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
      endcase
      while (bytes_sent < directed_bytes.size() + (phase + 1) * BytesPerPhase)
        send_random_burst();
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // drain every closed frame, then let the pipeline settle
    while (frames_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("received %0d bytes over four pressure phases, %0d closed frames checked",
             bytes_sent, frames_done);
    $display("%0d field mismatches", mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/efdc_pkg.sv
src/efdc_front.sv
src/efdc_queue.sv
src/efdc_back.sv
src/escaped_frame_decoder_checksum_top.sv
src/efdc_checker.sv
tb/sv/efdc_frame_checker.sv
tb/sv/escaped_frame_decoder_checksum_top_tb.sv
